### rtl/core/srs_pkg.sv
package srs_pkg;

    localparam int ROWS_DEF        = 4;
    localparam int COLS_DEF        = 256;
    localparam int VERTEX_BITS_DEF = 20;

    localparam int VTX_W     = 20;
    localparam int HASH_REGS = 4;
    localparam int HASH_W    = 60;
    localparam int HALF_W    = 30;
    localparam int COLS_W    = 9;
    localparam int CFG_IDX_W = 3;
    localparam int ROW_W     = 2;
    localparam int COL_W     = 8;

    localparam int CNT_W = 24;
    localparam int IDX_W = 48;
    localparam int SQ_W  = 64;

    localparam logic [HALF_W-1:0] PRIME  = 30'd1073741789;
    localparam int                FOLD_K = 35;

    localparam int MOD_STEP = 6;
    localparam int MOD_CYC  = HALF_W / MOD_STEP;
    localparam int QUO_STEP = 4;
    localparam int QUO_CYC  = IDX_W / QUO_STEP;
    localparam int STEP_W   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HASH0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HASH1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HASH2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HASH3  = 3'd5;

    typedef enum logic [1:0] {
        KIND_IGNORE = 2'd0,
        KIND_UPDATE = 2'd1,
        KIND_QUERY  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic             neg;
        logic [VTX_W-1:0] vertex;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } qhead_t;

    typedef struct packed {
        logic clearing;
    } back_stat_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [IDX_W-1:0] idx;
        logic [SQ_W-1:0]  sq;
    } cell_t;

endpackage

### rtl/core/srs_front.sv
module srs_front #(
    parameter int ROWS        = srs_pkg::ROWS_DEF,
    parameter int COLS        = srs_pkg::COLS_DEF,
    parameter int VERTEX_BITS = srs_pkg::VERTEX_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      action,
    input  logic [srs_pkg::VTX_W-1:0] end_a,
    input  logic [srs_pkg::VTX_W-1:0] end_b,
    input  logic signed [1:0]         weight,
    input  logic [srs_pkg::ROW_W-1:0] query_row,
    input  logic [srs_pkg::COL_W-1:0] query_col,
    input  logic [srs_pkg::VTX_W-1:0] target,
    input  srs_pkg::back_stat_t       stat,
    output srs_pkg::qhead_t           head,
    input  logic                      pop
);
    import srs_pkg::*;

    localparam logic [VTX_W-1:0] VMASK = VTX_W'((64'd1 << VERTEX_BITS) - 64'd1);

    logic [VTX_W-1:0] ea;
    logic [VTX_W-1:0] eb;
    logic [VTX_W-1:0] tv;
    item_t            cls;
    item_t            fifo_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             push;

    assign ea = end_a & VMASK;
    assign eb = end_b & VMASK;
    assign tv = target & VMASK;

    always_comb
    begin
        cls        = '0;
        cls.kind   = KIND_IGNORE;
        cls.neg    = weight[1];
        cls.row    = query_row;
        cls.col    = query_col;
        if (action)
        begin
            if (32'(query_row) < ROWS && 32'(query_col) < COLS)
                cls.kind = KIND_QUERY;
        end
        else if (weight[0])
        begin
            if (ea == tv)
            begin
                cls.kind   = KIND_UPDATE;
                cls.vertex = eb;
            end
            else if (eb == tv)
            begin
                cls.kind   = KIND_UPDATE;
                cls.vertex = ea;
            end
        end
    end

    assign in_ready   = (cnt_reg != 2'd2) && !stat.clearing;
    assign push       = in_valid && in_ready;
    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

### rtl/core/srs_back.sv
module srs_back #(
    parameter int ROWS = srs_pkg::ROWS_DEF,
    parameter int COLS = srs_pkg::COLS_DEF
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic [srs_pkg::COLS_W-1:0]                          cols_in_use,
    input  logic [srs_pkg::HASH_REGS-1:0][srs_pkg::HASH_W-1:0]  row_hash,
    input  srs_pkg::qhead_t                                     head,
    output logic                                                pop,
    output srs_pkg::back_stat_t                                 stat,
    output logic                                                out_valid,
    input  logic                                                out_ready,
    output logic                                                incident,
    output logic                                                cell_one_sparse,
    output logic [srs_pkg::VTX_W-1:0]                           recovered_vertex
);
    import srs_pkg::*;

    localparam int DEPTH  = ROWS * COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [14:0] {
        S_CLEAR = 15'h0001,
        S_IDLE  = 15'h0002,
        S_SQ    = 15'h0004,
        S_MUL   = 15'h0008,
        S_FOLD1 = 15'h0010,
        S_FOLD2 = 15'h0020,
        S_DIV   = 15'h0040,
        S_RD    = 15'h0080,
        S_WR    = 15'h0100,
        S_QRD   = 15'h0200,
        S_QMAG  = 15'h0400,
        S_QMUL  = 15'h0800,
        S_QCMP  = 15'h1000,
        S_QDIV  = 15'h2000,
        S_EMIT  = 15'h4000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    cell_t               mem [DEPTH];
    cell_t               rdata_reg;
    cell_t               wdata;
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;
    item_t               item_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [2*VTX_W-1:0]  sq_reg;
    logic [HALF_W+VTX_W-1:0] prod_reg;
    logic [HALF_W:0]     fold_reg;
    logic [HALF_W-1:0]   h_reg;
    logic [COLS_W-1:0]   rem_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [COLS_W-1:0]   m_eff;

    logic [HALF_W+VTX_W:0] tsum;
    logic [HALF_W:0]     fold1;
    logic [HALF_W:0]     y2;
    logic [HALF_W-1:0]   hmod;
    logic [COLS_W-1:0]   rem_next;
    logic [HALF_W-1:0]   h_next;
    logic [COLS_W:0]     mt;
    logic [ADDR_W-1:0]   upd_addr;
    logic [ADDR_W-1:0]   qry_addr;

    logic [CNT_W-1:0]    pm_reg;
    logic [IDX_W-1:0]    im_reg;
    logic [SQ_W-1:0]     tm_reg;
    logic                pn_reg;
    logic                ineg_reg;
    logic                tn_reg;
    logic [2*CNT_W-1:0]  p_hh_reg;
    logic [2*CNT_W-1:0]  p_hl_reg;
    logic [2*CNT_W-1:0]  p_ll_reg;
    logic [CNT_W+31:0]   r_hi_reg;
    logic [CNT_W+31:0]   r_lo_reg;
    logic [95:0]         lhs;
    logic [95:0]         rhs;
    logic                ok;
    logic [IDX_W-1:0]    dvd_reg;
    logic [CNT_W-1:0]    qrem_reg;
    logic [VTX_W-1:0]    quo_reg;
    logic [IDX_W-1:0]    dvd_next;
    logic [CNT_W-1:0]    qrem_next;
    logic [VTX_W-1:0]    quo_next;
    logic [CNT_W:0]      qt;

    logic                res_inc_reg;
    logic                res_ok_reg;
    logic [VTX_W-1:0]    res_vtx_reg;
    logic                out_valid_reg;
    logic                out_inc_reg;
    logic                out_ok_reg;
    logic [VTX_W-1:0]    out_vtx_reg;
    logic                emit;

    always_comb
    begin
        if (cols_in_use == '0)
            m_eff = COLS_W'(1);
        else if (32'(cols_in_use) > COLS)
            m_eff = COLS_W'(COLS);
        else
            m_eff = cols_in_use;
    end

    // mod-prime folding: 2^30 = 35 (mod P)
    assign tsum  = (HALF_W+VTX_W+1)'(prod_reg)
                 + (HALF_W+VTX_W+1)'(row_hash[row_reg][HALF_W-1:0]);
    assign fold1 = (HALF_W+1)'(tsum[HALF_W+VTX_W:HALF_W] * FOLD_K)
                 + (HALF_W+1)'(tsum[HALF_W-1:0]);
    assign y2    = (HALF_W+1)'(fold_reg[HALF_W] ? FOLD_K : 0)
                 + (HALF_W+1)'(fold_reg[HALF_W-1:0]);
    assign hmod  = (y2 >= (HALF_W+1)'(PRIME)) ? HALF_W'(y2 - (HALF_W+1)'(PRIME))
                                               : y2[HALF_W-1:0];

    // column remainder, MOD_STEP bits per cycle
    always_comb
    begin
        rem_next = rem_reg;
        h_next   = h_reg;
        mt       = '0;
        for (int k = 0; k < MOD_STEP; k++)
        begin
            mt     = {rem_next, h_next[HALF_W-1]};
            h_next = {h_next[HALF_W-2:0], 1'b0};
            if (mt >= {1'b0, m_eff})
                mt = mt - {1'b0, m_eff};
            rem_next = mt[COLS_W-1:0];
        end
    end

    assign upd_addr = ADDR_W'(32'(row_reg) * COLS + 32'(rem_next));
    assign qry_addr = ADDR_W'(32'(head.item.row) * COLS + 32'(head.item.col));

    // quotient, QUO_STEP bits per cycle; only the low bits are kept
    always_comb
    begin
        qrem_next = qrem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        qt        = '0;
        for (int k = 0; k < QUO_STEP; k++)
        begin
            qt       = {qrem_next, dvd_next[IDX_W-1]};
            dvd_next = {dvd_next[IDX_W-2:0], 1'b0};
            quo_next = {quo_next[VTX_W-2:0], (qt >= {1'b0, pm_reg})};
            if (qt >= {1'b0, pm_reg})
                qt = qt - {1'b0, pm_reg};
            qrem_next = qt[CNT_W-1:0];
        end
    end

    assign lhs = {p_hh_reg, 48'd0} + 96'({p_hl_reg, 25'd0}) + 96'(p_ll_reg);
    assign rhs = 96'({r_hi_reg, 32'd0}) + 96'(r_lo_reg);
    assign ok  = (pm_reg != '0) && (lhs == rhs) && !((tm_reg != '0) && (pn_reg != tn_reg));

    always_comb
    begin
        we    = 1'b0;
        waddr = addr_reg;
        wdata = '0;
        if (state_reg == S_CLEAR)
        begin
            we    = 1'b1;
            waddr = clr_addr_reg;
        end
        else if (state_reg == S_WR)
        begin
            we = 1'b1;
            if (item_reg.neg)
            begin
                wdata.cnt = rdata_reg.cnt - CNT_W'(1);
                wdata.idx = rdata_reg.idx - IDX_W'(item_reg.vertex);
                wdata.sq  = rdata_reg.sq - SQ_W'(sq_reg);
            end
            else
            begin
                wdata.cnt = rdata_reg.cnt + CNT_W'(1);
                wdata.idx = rdata_reg.idx + IDX_W'(item_reg.vertex);
                wdata.sq  = rdata_reg.sq + SQ_W'(sq_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[addr_reg];
    end

    assign pop  = (state_reg == S_IDLE) && head.valid;
    assign emit = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
                if (32'(clr_addr_reg) == DEPTH - 1)
                    state_next = S_IDLE;
            S_IDLE:
                if (head.valid)
                begin
                    unique case (head.item.kind)
                        KIND_UPDATE: state_next = S_SQ;
                        KIND_QUERY:  state_next = S_QRD;
                        default:     state_next = S_EMIT;
                    endcase
                end
            S_SQ:    state_next = S_MUL;
            S_MUL:   state_next = S_FOLD1;
            S_FOLD1: state_next = S_FOLD2;
            S_FOLD2: state_next = S_DIV;
            S_DIV:
                if (step_reg == STEP_W'(MOD_CYC - 1))
                    state_next = S_RD;
            S_RD:    state_next = S_WR;
            S_WR:
                if (row_reg == ROW_W'(ROWS - 1))
                    state_next = S_EMIT;
                else
                    state_next = S_MUL;
            S_QRD:   state_next = S_QMAG;
            S_QMAG:  state_next = S_QMUL;
            S_QMUL:  state_next = S_QCMP;
            S_QCMP:
                if (ok)
                    state_next = S_QDIV;
                else
                    state_next = S_EMIT;
            S_QDIV:
                if (step_reg == STEP_W'(QUO_CYC - 1))
                    state_next = S_EMIT;
            S_EMIT:
                if (emit)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg    <= head.item;
            addr_reg    <= qry_addr;
            res_inc_reg <= 1'b0;
            res_ok_reg  <= 1'b0;
            res_vtx_reg <= '0;
        end
        if (state_reg == S_SQ)
        begin
            sq_reg  <= item_reg.vertex * item_reg.vertex;
            row_reg <= '0;
        end
        if (state_reg == S_MUL)
            prod_reg <= row_hash[row_reg][HASH_W-1:HALF_W] * item_reg.vertex;
        if (state_reg == S_FOLD1)
            fold_reg <= fold1;
        if (state_reg == S_FOLD2)
        begin
            h_reg    <= hmod;
            rem_reg  <= '0;
            step_reg <= '0;
        end
        if (state_reg == S_DIV)
        begin
            h_reg    <= h_next;
            rem_reg  <= rem_next;
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(MOD_CYC - 1))
                addr_reg <= upd_addr;
        end
        if (state_reg == S_WR)
        begin
            row_reg <= row_reg + ROW_W'(1);
            if (row_reg == ROW_W'(ROWS - 1))
                res_inc_reg <= 1'b1;
        end
        if (state_reg == S_QMAG)
        begin
            pn_reg   <= rdata_reg.cnt[CNT_W-1];
            ineg_reg <= rdata_reg.idx[IDX_W-1];
            tn_reg   <= rdata_reg.sq[SQ_W-1];
            pm_reg   <= rdata_reg.cnt[CNT_W-1] ? -rdata_reg.cnt : rdata_reg.cnt;
            im_reg   <= rdata_reg.idx[IDX_W-1] ? -rdata_reg.idx : rdata_reg.idx;
            tm_reg   <= rdata_reg.sq[SQ_W-1] ? -rdata_reg.sq : rdata_reg.sq;
        end
        if (state_reg == S_QMUL)
        begin
            p_hh_reg <= im_reg[IDX_W-1:CNT_W] * im_reg[IDX_W-1:CNT_W];
            p_hl_reg <= im_reg[IDX_W-1:CNT_W] * im_reg[CNT_W-1:0];
            p_ll_reg <= im_reg[CNT_W-1:0] * im_reg[CNT_W-1:0];
            r_hi_reg <= pm_reg * tm_reg[SQ_W-1:32];
            r_lo_reg <= pm_reg * tm_reg[31:0];
        end
        if (state_reg == S_QCMP)
        begin
            dvd_reg  <= im_reg;
            qrem_reg <= '0;
            quo_reg  <= '0;
            step_reg <= '0;
        end
        if (state_reg == S_QDIV)
        begin
            dvd_reg  <= dvd_next;
            qrem_reg <= qrem_next;
            quo_reg  <= quo_next;
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(QUO_CYC - 1))
            begin
                res_ok_reg  <= 1'b1;
                res_vtx_reg <= (ineg_reg != pn_reg) ? -quo_next : quo_next;
            end
        end
        if (emit)
        begin
            out_inc_reg <= res_inc_reg;
            out_ok_reg  <= res_ok_reg;
            out_vtx_reg <= res_vtx_reg;
        end
    end

    assign stat.clearing    = (state_reg == S_CLEAR);
    assign out_valid        = out_valid_reg;
    assign incident         = out_inc_reg;
    assign cell_one_sparse  = out_ok_reg;
    assign recovered_vertex = out_vtx_reg;

endmodule

### rtl/core/sparse_recovery_sketch.sv
// Flow: an ignored update or out-of-range query goes straight to the result; a
// query reads its cell, tests it and divides only when the test passes; an incident
// update hashes and writes each row in turn before its result.
// Throughput: one item per back-end pass, which holds in S_EMIT while the output stalls;
// a 2-entry queue plus an output register keep the input open meanwhile.
// Reset: config returns to defaults; the sketch memory is zeroed by a sweep over
// all ROWS*COLS entries, during which in_ready stays low.
module sparse_recovery_sketch #(
    parameter int ROWS        = srs_pkg::ROWS_DEF,
    parameter int COLS        = srs_pkg::COLS_DEF,
    parameter int VERTEX_BITS = srs_pkg::VERTEX_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [srs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srs_pkg::HASH_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [srs_pkg::VTX_W-1:0]     end_a,
    input  logic [srs_pkg::VTX_W-1:0]     end_b,
    input  logic signed [1:0]             weight,
    input  logic [srs_pkg::ROW_W-1:0]     query_row,
    input  logic [srs_pkg::COL_W-1:0]     query_col,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          incident,
    output logic                          cell_one_sparse,
    output logic [srs_pkg::VTX_W-1:0]     recovered_vertex
);
    import srs_pkg::*;

    logic [VTX_W-1:0]                   target_reg;
    logic [COLS_W-1:0]                  cols_reg;
    logic [HASH_REGS-1:0][HASH_W-1:0]   hash_reg;
    qhead_t                             head;
    back_stat_t                         stat;
    logic                               pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            cols_reg   <= COLS_W'(200);
            hash_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index) inside
                REG_TARGET: target_reg <= cfg_data[VTX_W-1:0];
                REG_COLS:   cols_reg   <= cfg_data[COLS_W-1:0];
                REG_HASH0, REG_HASH1, REG_HASH2, REG_HASH3:
                    hash_reg[2'(cfg_index - REG_HASH0)] <= cfg_data;
                default: ;
            endcase
        end
    end

    srs_front #(
        .ROWS        (ROWS),
        .COLS        (COLS),
        .VERTEX_BITS (VERTEX_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .end_a     (end_a),
        .end_b     (end_b),
        .weight    (weight),
        .query_row (query_row),
        .query_col (query_col),
        .target    (target_reg),
        .stat      (stat),
        .head      (head),
        .pop       (pop)
    );

    srs_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cols_in_use      (cols_reg),
        .row_hash         (hash_reg),
        .head             (head),
        .pop              (pop),
        .stat             (stat),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .incident         (incident),
        .cell_one_sparse  (cell_one_sparse),
        .recovered_vertex (recovered_vertex)
    );

endmodule

### rtl/core/srs_checker.sv
module srs_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      incident,
    input logic                      cell_one_sparse,
    input logic [srs_pkg::VTX_W-1:0] recovered_vertex
);
    import srs_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(recovered_vertex) && $stable(incident))
        else $error("result changed while stalled");

    a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(incident && cell_one_sparse))
        else $error("update and query flags both set");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !cell_one_sparse |-> recovered_vertex == '0)
        else $error("vertex reported without passing test");

endmodule

bind sparse_recovery_sketch srs_checker u_srs_checker (.*);
